// ===== rtl/chip8_instruction_execute_unit_macros.svh =====
// ----------------------------------------------------------------------------
// CHIP-8 execute unit assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CHIP8_INSTRUCTION_EXECUTE_UNIT_MACROS_SVH
`define CHIP8_INSTRUCTION_EXECUTE_UNIT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define C8EX_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define C8EX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/c8ex_pkg.sv =====
// ----------------------------------------------------------------------------
// CHIP-8 execute unit package
// Opcode groups, action codes and the structs passed between the modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package c8ex_pkg;

  // Top nibble of the instruction word.
  localparam logic [3:0] OPC_SYS     = 4'h0;
  localparam logic [3:0] OPC_JUMP    = 4'h1;
  localparam logic [3:0] OPC_CALL    = 4'h2;
  localparam logic [3:0] OPC_SEQ_IMM = 4'h3;
  localparam logic [3:0] OPC_SNE_IMM = 4'h4;
  localparam logic [3:0] OPC_SEQ_REG = 4'h5;
  localparam logic [3:0] OPC_LD_IMM  = 4'h6;
  localparam logic [3:0] OPC_ADD_IMM = 4'h7;
  localparam logic [3:0] OPC_ALU     = 4'h8;
  localparam logic [3:0] OPC_SNE_REG = 4'h9;
  localparam logic [3:0] OPC_LD_IDX  = 4'hA;
  localparam logic [3:0] OPC_JUMP_V0 = 4'hB;
  localparam logic [3:0] OPC_RAND    = 4'hC;
  localparam logic [3:0] OPC_DRAW    = 4'hD;
  localparam logic [3:0] OPC_KEY     = 4'hE;
  localparam logic [3:0] OPC_MISC    = 4'hF;

  // Whole system words.
  localparam logic [15:0] INS_CLS = 16'h00E0;
  localparam logic [15:0] INS_RET = 16'h00EE;

  // Low nibble of the ALU group.
  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  // Low byte of the key and miscellaneous groups.
  localparam logic [7:0] KEY_DOWN  = 8'h9E;
  localparam logic [7:0] KEY_UP    = 8'hA1;
  localparam logic [7:0] MISC_GDT  = 8'h07;
  localparam logic [7:0] MISC_WKEY = 8'h0A;
  localparam logic [7:0] MISC_SDT  = 8'h15;
  localparam logic [7:0] MISC_SST  = 8'h18;
  localparam logic [7:0] MISC_ADDI = 8'h1E;
  localparam logic [7:0] MISC_FONT = 8'h29;
  localparam logic [7:0] MISC_BCD  = 8'h33;
  localparam logic [7:0] MISC_SAVE = 8'h55;
  localparam logic [7:0] MISC_LOAD = 8'h65;

  // Action request codes.
  localparam logic [3:0] ACT_NONE     = 4'd0;
  localparam logic [3:0] ACT_CLEAR    = 4'd1;
  localparam logic [3:0] ACT_DRAW     = 4'd2;
  localparam logic [3:0] ACT_BCD      = 4'd3;
  localparam logic [3:0] ACT_SAVE     = 4'd4;
  localparam logic [3:0] ACT_LOAD     = 4'd5;
  localparam logic [3:0] ACT_WAITKEY  = 4'd6;
  localparam logic [3:0] ACT_SETDELAY = 4'd7;
  localparam logic [3:0] ACT_SETSOUND = 4'd8;

  // Item kinds.
  localparam logic OP_EXEC  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // The flag register lives in flip-flops, not in the register memory.
  localparam logic [3:0] VF_ADDR = 4'hF;

  // Program counter after reset.
  localparam logic [15:0] START_ADDR_RESET = 16'h0200;

  // One input word.
  typedef struct packed {
    logic        op;
    logic [15:0] instruction;
    logic [15:0] key_mask;
    logic [7:0]  delay_value;
    logic [7:0]  random_byte;
    logic [3:0]  wb_index;
    logic [7:0]  wb_value;
  } item_t;

  // Everything one item changes or reports.
  typedef struct packed {
    logic [15:0] next_pc;
    logic [15:0] index;
    logic [3:0]  act;
    logic [3:0]  areg;
    logic [7:0]  aval;
    logic [7:0]  avaly;
    logic [3:0]  rows;
    logic        reg_we;
    logic [3:0]  reg_addr;
    logic [7:0]  reg_data;
    logic        flag_we;
    logic        flag_data;
    logic        push;
    logic        pop;
    logic [15:0] ret_addr;
  } exec_res_t;

endpackage

// ===== rtl/c8ex_alu.sv =====
// ----------------------------------------------------------------------------
// CHIP-8 execute logic
// Decodes one item and computes the new program counter, index, register
// write, flag write, stack operation and action request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module c8ex_alu #(
  parameter int FONT_BASE = 4016
) (
  input  c8ex_pkg::item_t     item,
  input  logic [15:0]         pc,
  input  logic [15:0]         index,
  input  logic [7:0]          va,       // VX, or V0 for the offset jump
  input  logic [7:0]          vb,       // VY
  input  logic [15:0]         ret_data, // return stack entry above the pointer
  output c8ex_pkg::exec_res_t res
);
  import c8ex_pkg::*;

  logic [15:0] ins;
  logic [3:0]  x;
  logic [3:0]  n;
  logic [7:0]  kk;
  logic [15:0] nnn;
  logic [15:0] pc2;
  logic        skip;
  logic        key_hit;
  logic [8:0]  sum9;

  assign ins  = item.instruction;
  assign x    = ins[11:8];
  assign n    = ins[3:0];
  assign kk   = ins[7:0];
  assign nnn  = {4'd0, ins[11:0]};
  assign pc2  = pc + 16'd2;
  assign sum9 = {1'b0, va} + {1'b0, vb};

  // Keys above fifteen count as released.
  assign key_hit = (va[7:4] == 4'd0) && item.key_mask[va[3:0]];

  always_comb begin
    res          = '0;
    skip         = 1'b0;
    res.next_pc  = pc2;
    res.index    = index;
    res.reg_addr = x;
    res.ret_addr = pc2;
    if (item.op == OP_WRITE) begin
      res.next_pc  = pc;
      res.reg_we   = 1'b1;
      res.reg_addr = item.wb_index;
      res.reg_data = item.wb_value;
    end else begin
      unique case (ins[15:12])
        OPC_SYS: begin
          if (ins == INS_CLS) begin
            res.act = ACT_CLEAR;
          end else if (ins == INS_RET) begin
            res.pop     = 1'b1;
            res.next_pc = ret_data;
          end
        end
        OPC_JUMP: res.next_pc = nnn;
        OPC_CALL: begin
          res.push    = 1'b1;
          res.next_pc = nnn;
        end
        OPC_SEQ_IMM: skip = (va == kk);
        OPC_SNE_IMM: skip = (va != kk);
        OPC_SEQ_REG: skip = (va == vb);
        OPC_LD_IMM: begin
          res.reg_we   = 1'b1;
          res.reg_data = kk;
        end
        OPC_ADD_IMM: begin
          res.reg_we   = 1'b1;
          res.reg_data = va + kk;
        end
        OPC_ALU: begin
          res.reg_we = 1'b1;
          unique case (n)
            ALU_MOV: res.reg_data = vb;
            ALU_OR:  res.reg_data = va | vb;
            ALU_AND: res.reg_data = va & vb;
            ALU_XOR: res.reg_data = va ^ vb;
            ALU_ADD: begin
              res.reg_data  = sum9[7:0];
              res.flag_we   = 1'b1;
              res.flag_data = sum9[8];
            end
            ALU_SUB: begin
              res.reg_data  = va - vb;
              res.flag_we   = 1'b1;
              res.flag_data = (va >= vb);
            end
            ALU_SHR: begin
              res.reg_data  = {1'b0, va[7:1]};
              res.flag_we   = 1'b1;
              res.flag_data = va[0];
            end
            ALU_SUBN: begin
              res.reg_data  = vb - va;
              res.flag_we   = 1'b1;
              res.flag_data = (vb >= va);
            end
            ALU_SHL: begin
              res.reg_data  = {va[6:0], 1'b0};
              res.flag_we   = 1'b1;
              res.flag_data = va[7];
            end
            default: res.reg_we = 1'b0;
          endcase
        end
        OPC_SNE_REG: skip = (va != vb);
        OPC_LD_IDX:  res.index = nnn;
        OPC_JUMP_V0: res.next_pc = nnn + {8'd0, va};
        OPC_RAND: begin
          res.reg_we   = 1'b1;
          res.reg_data = item.random_byte & kk;
        end
        OPC_DRAW: begin
          res.act   = ACT_DRAW;
          res.aval  = va;
          res.avaly = vb;
          res.rows  = n;
        end
        OPC_KEY: begin
          if (kk == KEY_DOWN) begin
            skip = key_hit;
          end else if (kk == KEY_UP) begin
            skip = !key_hit;
          end
        end
        OPC_MISC: begin
          unique case (kk)
            MISC_GDT: begin
              res.reg_we   = 1'b1;
              res.reg_data = item.delay_value;
            end
            MISC_WKEY: begin
              res.act  = ACT_WAITKEY;
              res.areg = x;
            end
            MISC_SDT: begin
              res.act  = ACT_SETDELAY;
              res.aval = va;
            end
            MISC_SST: begin
              res.act  = ACT_SETSOUND;
              res.aval = va;
            end
            MISC_ADDI: res.index = index + {8'd0, va};
            MISC_FONT: res.index = 16'(FONT_BASE) + {6'd0, va, 2'b00} + {8'd0, va};
            MISC_BCD: begin
              res.act  = ACT_BCD;
              res.aval = va;
            end
            MISC_SAVE: begin
              res.act  = ACT_SAVE;
              res.areg = x;
            end
            MISC_LOAD: begin
              res.act  = ACT_LOAD;
              res.areg = x;
            end
            default: ;
          endcase
        end
      endcase
      if (skip) begin
        res.next_pc = pc2 + 16'd2;
      end
    end
  end

endmodule

// ===== rtl/chip8_instruction_execute_unit.sv =====
// Path: an accepted word is registered into the execute stage; its result
// word is registered into the output register when that word moves on.
// Throughput: one word per cycle when the output is free; the register and
// stack memories read at acceptance, write back as the word moves to output.
// Reset: synchronous, active low; PC = 0x0200, index, VF and valid bits
// clear, stack pointer to the top entry. No clearing pass; ready at once.
// ----------------------------------------------------------------------------
// CHIP-8 instruction execute unit
// Two-stage pipeline around a register memory and a return stack memory,
// with forwarding from the committing word into the next one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chip8_instruction_execute_unit #(
  parameter int FONT_BASE   = 4016,
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: start address.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  // Input words.
  input  logic        in_tvalid,
  output logic        in_tready,
  // instruction, key_mask, delay_value, random_byte, wb_index, wb_value, pad
  input  logic [63:0] in_tdata,
  input  logic        in_tuser,   // op
  // Result words.
  output logic        out_tvalid,
  input  logic        out_tready,
  // next_pc, action_reg, action_value, action_value_y, sprite_rows, index_value
  output logic [55:0] out_tdata,
  output logic [3:0]  out_tuser   // action
);
  import c8ex_pkg::*;

  localparam int SP_W = $clog2(STACK_DEPTH);
  localparam logic [SP_W-1:0] SP_ONE = SP_W'(1);

  // Memories.
  logic [7:0]  reg_mem [16];
  logic [15:0] stk_mem [STACK_DEPTH];

  // Architectural flip-flops.
  logic [15:0]     start_addr_r;
  logic [15:0]     pc_r;
  logic [15:0]     index_r;
  logic [7:0]      vf_r;
  logic [SP_W-1:0] sp_r;
  logic [15:0]     valid_r;

  // Execute stage.
  logic        s1_valid_r;
  item_t       s1_item_r;
  logic [3:0]  ra_r;
  logic [3:0]  rb_r;
  logic [7:0]  rd_a_r;
  logic [7:0]  rd_b_r;
  logic        fw_a_hit_r;
  logic        fw_b_hit_r;
  logic [7:0]  fw_data_r;
  logic [15:0] stk_rd_r;
  logic        stk_hit_r;
  logic [15:0] stk_fw_r;

  // Output register.
  logic        out_valid_r;
  logic [15:0] out_pc_r;
  logic [3:0]  out_act_r;
  logic [3:0]  out_areg_r;
  logic [7:0]  out_aval_r;
  logic [7:0]  out_avaly_r;
  logic [3:0]  out_rows_r;
  logic [15:0] out_index_r;

  item_t           in_item;
  logic            in_acc;
  logic            adv;
  logic [3:0]      ra;
  logic [3:0]      rb;
  logic [7:0]      va;
  logic [7:0]      vb;
  logic [15:0]     ret_data;
  exec_res_t       res;
  logic            mem_we;
  logic            stk_we;
  logic [SP_W-1:0] sp_nxt;
  logic [SP_W-1:0] sp_eff;
  logic [SP_W-1:0] stk_raddr;

  // Unpack the input word.
  assign in_item.op          = in_tuser;
  assign in_item.instruction = in_tdata[15:0];
  assign in_item.key_mask    = in_tdata[31:16];
  assign in_item.delay_value = in_tdata[39:32];
  assign in_item.random_byte = in_tdata[47:40];
  assign in_item.wb_index    = in_tdata[51:48];
  assign in_item.wb_value    = in_tdata[59:52];

  // Handshakes: the executing word moves on whenever the output is free.
  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // The offset jump reads V0 through the X port.
  assign ra = (in_item.instruction[15:12] == OPC_JUMP_V0) ? 4'd0
                                                          : in_item.instruction[11:8];
  assign rb = in_item.instruction[7:4];

  // Operands: VF from flops, else forwarded write, else memory or reset zero.
  always_comb begin
    if (ra_r == VF_ADDR) begin
      va = vf_r;
    end else if (fw_a_hit_r) begin
      va = fw_data_r;
    end else begin
      va = valid_r[ra_r] ? rd_a_r : 8'd0;
    end
    if (rb_r == VF_ADDR) begin
      vb = vf_r;
    end else if (fw_b_hit_r) begin
      vb = fw_data_r;
    end else begin
      vb = valid_r[rb_r] ? rd_b_r : 8'd0;
    end
  end

  assign ret_data = stk_hit_r ? stk_fw_r : stk_rd_r;

  c8ex_alu #(
    .FONT_BASE(FONT_BASE)
  ) u_alu (
    .item     (s1_item_r),
    .pc       (pc_r),
    .index    (index_r),
    .va       (va),
    .vb       (vb),
    .ret_data (ret_data),
    .res      (res)
  );

  // Write enables and the stack pointer seen by the next word.
  assign mem_we = adv && res.reg_we && (res.reg_addr != VF_ADDR);
  assign stk_we = adv && res.push;

  always_comb begin
    priority if (res.push) begin
      sp_nxt = sp_r - SP_ONE;
    end else if (res.pop) begin
      sp_nxt = sp_r + SP_ONE;
    end else begin
      sp_nxt = sp_r;
    end
  end

  assign sp_eff    = adv ? sp_nxt : sp_r;
  assign stk_raddr = sp_eff + SP_ONE;

  // Register memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      reg_mem[res.reg_addr] <= res.reg_data;
    end
    if (in_acc) begin
      rd_a_r <= reg_mem[ra];
      rd_b_r <= reg_mem[rb];
    end
  end

  // Return stack memory.
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[sp_r] <= res.ret_addr;
    end
    if (in_acc) begin
      stk_rd_r <= stk_mem[stk_raddr];
    end
  end

  // Execute stage payload and forwarding from the write at acceptance.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r  <= in_item;
      ra_r       <= ra;
      rb_r       <= rb;
      fw_a_hit_r <= mem_we && (res.reg_addr == ra);
      fw_b_hit_r <= mem_we && (res.reg_addr == rb);
      fw_data_r  <= res.reg_data;
      stk_hit_r  <= stk_we && (sp_r == stk_raddr);
      stk_fw_r   <= res.ret_addr;
    end
  end

  // Control state and architectural registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_addr_r <= START_ADDR_RESET;
      pc_r         <= START_ADDR_RESET;
      index_r      <= 16'd0;
      vf_r         <= 8'd0;
      sp_r         <= SP_W'(STACK_DEPTH - 1);
      valid_r      <= 16'd0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        start_addr_r <= cfg_data;
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (adv) begin
        pc_r    <= res.next_pc;
        index_r <= res.index;
        sp_r    <= sp_nxt;
        // The flag lands after the result, so it wins when X is VF.
        if (res.flag_we) begin
          vf_r <= {7'd0, res.flag_data};
        end else if (res.reg_we && (res.reg_addr == VF_ADDR)) begin
          vf_r <= res.reg_data;
        end
      end
      if (mem_we) begin
        valid_r[res.reg_addr] <= 1'b1;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_pc_r    <= res.next_pc;
      out_act_r   <= res.act;
      out_areg_r  <= res.areg;
      out_aval_r  <= res.aval;
      out_avaly_r <= res.avaly;
      out_rows_r  <= res.rows;
      out_index_r <= res.index;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_act_r;
  assign out_tdata  = {out_index_r, out_rows_r, out_avaly_r, out_aval_r,
                       out_areg_r, out_pc_r};

  // Checks on the pipeline and the stack.
`include "chip8_instruction_execute_unit_macros.svh"
  `C8EX_ASSERT_NEXT(a_adv_fills_out, adv, out_valid_r, "commit left output empty")
  `C8EX_ASSERT_SAME(a_push_pop_excl, s1_valid_r, !(res.push && res.pop), "push and pop")
  `C8EX_ASSERT_SAME(a_no_mem_vf, mem_we, res.reg_addr != VF_ADDR, "VF written to memory")
  `C8EX_ASSERT_NEXT(a_push_dec, adv && res.push, sp_r == SP_W'($past(sp_r) - SP_ONE), "push sp")

endmodule

// ===== dv/execute_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CHIP-8 execute unit checker
// Watches the configuration, input and result channels of the execute unit.
// It keeps its own copy of the interpreter state, predicts the result word of
// every accepted input word, and compares each result word in order.
// ----------------------------------------------------------------------------

module execute_unit_checker #(
  parameter int FONT_BASE = 4016
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,
  input  logic [3:0]  out_tuser,
  output int          pending_count,
  output int          fail_count
);
  import c8ex_pkg::*;

  typedef struct packed {
    logic [15:0] next_pc;
    logic [3:0]  action;
    logic [3:0]  action_reg;
    logic [7:0]  action_value;
    logic [7:0]  action_value_y;
    logic [3:0]  sprite_rows;
    logic [15:0] index_value;
  } result_word_t;

  // Interpreter state as the block should hold it.
  logic [15:0]  start_addr;
  logic [15:0]  prog_counter;
  logic [15:0]  index_reg;
  logic [7:0]   data_regs [16];
  logic [15:0]  return_stack [16];
  logic [3:0]   stack_ptr;
  result_word_t pending_results [$];

  // A key number above 15 never counts as pressed.
  function automatic logic key_pressed(logic [15:0] mask, logic [7:0] key);
    return (key <= 8'd15) && mask[key[3:0]];
  endfunction

  // Runs one input word against the state and returns its result word.
  task automatic execute_word(input logic op, input logic [63:0] data,
                              output result_word_t res);
    logic [15:0] ins;
    logic [15:0] keys;
    logic [7:0]  delay_val;
    logic [7:0]  rnd;
    logic [3:0]  wb_idx;
    logic [7:0]  wb_val;
    logic [3:0]  x;
    logic [3:0]  y;
    logic [3:0]  n;
    logic [7:0]  kk;
    logic [15:0] nnn;
    logic [7:0]  vx;
    logic [7:0]  vy;
    logic [15:0] pc;
    logic [8:0]  sum;
    logic        skip;
    ins       = data[15:0];
    keys      = data[31:16];
    delay_val = data[39:32];
    rnd       = data[47:40];
    wb_idx    = data[51:48];
    wb_val    = data[59:52];
    res       = '0;
    if (op == OP_WRITE) begin
      data_regs[wb_idx] = wb_val;
    end else begin
      x    = ins[11:8];
      y    = ins[7:4];
      n    = ins[3:0];
      kk   = ins[7:0];
      nnn  = {4'h0, ins[11:0]};
      vx   = data_regs[x];
      vy   = data_regs[y];
      pc   = prog_counter + 16'd2;
      skip = 1'b0;
      case (ins[15:12])
        OPC_SYS: begin
          if (ins == INS_CLS) begin
            res.action = ACT_CLEAR;
          end else if (ins == INS_RET) begin
            stack_ptr = stack_ptr + 4'd1;
            pc        = return_stack[stack_ptr];
          end
        end
        OPC_JUMP: pc = nnn;
        OPC_CALL: begin
          return_stack[stack_ptr] = pc;
          stack_ptr               = stack_ptr - 4'd1;
          pc                      = nnn;
        end
        OPC_SEQ_IMM: skip = (vx == kk);
        OPC_SNE_IMM: skip = (vx != kk);
        OPC_SEQ_REG: skip = (vx == vy);
        OPC_LD_IMM:  data_regs[x] = kk;
        OPC_ADD_IMM: data_regs[x] = vx + kk;
        OPC_ALU: begin
          // The result lands in VX first, so the flag wins when X is VF.
          case (n)
            ALU_MOV: data_regs[x] = vy;
            ALU_OR:  data_regs[x] = vx | vy;
            ALU_AND: data_regs[x] = vx & vy;
            ALU_XOR: data_regs[x] = vx ^ vy;
            ALU_ADD: begin
              sum                = {1'b0, vx} + {1'b0, vy};
              data_regs[x]       = sum[7:0];
              data_regs[VF_ADDR] = {7'd0, sum[8]};
            end
            ALU_SUB: begin
              data_regs[x]       = vx - vy;
              data_regs[VF_ADDR] = (vx < vy) ? 8'd0 : 8'd1;
            end
            ALU_SHR: begin
              data_regs[x]       = vx >> 1;
              data_regs[VF_ADDR] = {7'd0, vx[0]};
            end
            ALU_SUBN: begin
              data_regs[x]       = vy - vx;
              data_regs[VF_ADDR] = (vy < vx) ? 8'd0 : 8'd1;
            end
            ALU_SHL: begin
              data_regs[x]       = {vx[6:0], 1'b0};
              data_regs[VF_ADDR] = {7'd0, vx[7]};
            end
            default: ;
          endcase
        end
        OPC_SNE_REG: skip = (vx != vy);
        OPC_LD_IDX:  index_reg = nnn;
        OPC_JUMP_V0: pc = nnn + {8'h00, data_regs[0]};
        OPC_RAND:    data_regs[x] = rnd & kk;
        OPC_DRAW: begin
          res.action         = ACT_DRAW;
          res.action_value   = vx;
          res.action_value_y = vy;
          res.sprite_rows    = n;
        end
        OPC_KEY: begin
          if (kk == KEY_DOWN) begin
            skip = key_pressed(keys, vx);
          end else if (kk == KEY_UP) begin
            skip = !key_pressed(keys, vx);
          end
        end
        OPC_MISC: begin
          case (kk)
            MISC_GDT:  data_regs[x] = delay_val;
            MISC_WKEY: begin
              res.action     = ACT_WAITKEY;
              res.action_reg = x;
            end
            MISC_SDT: begin
              res.action       = ACT_SETDELAY;
              res.action_value = vx;
            end
            MISC_SST: begin
              res.action       = ACT_SETSOUND;
              res.action_value = vx;
            end
            MISC_ADDI: index_reg = index_reg + {8'h00, vx};
            MISC_FONT: index_reg = 16'(FONT_BASE) + {8'h00, vx} * 16'd5;
            MISC_BCD: begin
              res.action       = ACT_BCD;
              res.action_value = vx;
            end
            MISC_SAVE: begin
              res.action     = ACT_SAVE;
              res.action_reg = x;
            end
            MISC_LOAD: begin
              res.action     = ACT_LOAD;
              res.action_reg = x;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      if (skip) begin
        pc = pc + 16'd2;
      end
      prog_counter = pc;
    end
    res.next_pc     = prog_counter;
    res.index_value = index_reg;
  endtask

  // Channel monitor: predict on every accepted input word, compare on every
  // accepted result word.
  always @(posedge clk) begin
    result_word_t want;
    result_word_t got;
    if (!rst_n) begin
      start_addr   = START_ADDR_RESET;
      prog_counter = START_ADDR_RESET;
      index_reg    = '0;
      stack_ptr    = 4'hF;
      for (int i = 0; i < 16; i++) begin
        data_regs[i]    = '0;
        return_stack[i] = '0;
      end
      pending_results.delete();
    end else begin
      // The start address is only recorded; reset loads the fixed start address and is asserted once.
      if (cfg_valid && cfg_ready) begin
        start_addr = cfg_data;
      end
      if (in_tvalid && in_tready) begin
        execute_word(in_tuser, in_tdata, want);
        pending_results.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got.next_pc        = out_tdata[15:0];
        got.action_reg     = out_tdata[19:16];
        got.action_value   = out_tdata[27:20];
        got.action_value_y = out_tdata[35:28];
        got.sprite_rows    = out_tdata[39:36];
        got.index_value    = out_tdata[55:40];
        got.action         = out_tuser;
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected result word: pc=%h act=%0d reg=%0d val=%h valy=%h rows=%0d idx=%h",
                     got.next_pc, got.action, got.action_reg, got.action_value,
                     got.action_value_y, got.sprite_rows, got.index_value);
          end
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch: expected pc=%h act=%0d reg=%0d val=%h valy=%h rows=%0d idx=%h",
                       want.next_pc, want.action, want.action_reg, want.action_value,
                       want.action_value_y, want.sprite_rows, want.index_value);
              $display("          actual   pc=%h act=%0d reg=%0d val=%h valy=%h rows=%0d idx=%h",
                       got.next_pc, got.action, got.action_reg, got.action_value,
                       got.action_value_y, got.sprite_rows, got.index_value);
            end
          end
        end
      end
    end
    pending_count = pending_results.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CHIP-8 execute unit testbench
// Drives directed and random instruction and write-back words into the
// execute unit under several idle and stall mixes, rewrites the start
// address between phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------

module testbench;
  import c8ex_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_WORDS  = 235;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic [15:0] cfg_data   = 16'h0000;
  logic        in_tvalid  = 1'b0;
  logic [63:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tready = 1'b0;
  logic        cfg_ready;
  logic        in_tready;
  logic        out_tvalid;
  logic [55:0] out_tdata;
  logic [3:0]  out_tuser;

  int pending_count;
  int fail_count;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Shadow of the return stack pointer and of the entries written so far,
  // so that a return never reads an entry that no call has filled.
  logic [3:0]  call_sp      = 4'hF;
  logic [15:0] call_written = '0;

  chip8_instruction_execute_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  execute_unit_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .pending_count (pending_count),
    .fail_count    (fail_count)
  );

  always #5 clk = ~clk;

  // Cycle count and random back-pressure on the result channel.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    out_tready  <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic ret_allowed();
    logic [3:0] nxt;
    nxt = call_sp + 4'd1;
    return call_written[nxt];
  endfunction

  // Register values biased toward small numbers and the edges of a byte.
  function automatic logic [7:0] pick_value();
    case ($urandom_range(5))
      0, 1:    return 8'($urandom_range(15));
      2: begin
        case ($urandom_range(3))
          0:       return 8'h00;
          1:       return 8'hFF;
          2:       return 8'h80;
          default: return 8'h7F;
        endcase
      end
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // A random instruction word, mostly well-formed within each group.
  function automatic logic [15:0] pick_instruction();
    logic [3:0]  nib;
    logic [3:0]  x;
    logic [3:0]  y;
    logic [3:0]  n;
    logic [7:0]  kk;
    logic [15:0] ins;
    nib = 4'($urandom_range(15));
    x   = 4'($urandom_range(15));
    y   = 4'($urandom_range(15));
    kk  = ($urandom_range(3) == 0) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
    ins = {nib, x, kk};
    case (nib)
      OPC_SYS: begin
        case ($urandom_range(9))
          0, 1, 2, 3: ins = INS_RET;
          4, 5, 6:    ins = INS_CLS;
          default:    ins = {4'h0, 12'($urandom_range(12'hFFF))};
        endcase
      end
      OPC_ALU: begin
        case ($urandom_range(9))
          0:       n = ALU_MOV;
          1:       n = ALU_OR;
          2:       n = ALU_AND;
          3:       n = ALU_XOR;
          4:       n = ALU_ADD;
          5:       n = ALU_SUB;
          6:       n = ALU_SHR;
          7:       n = ALU_SUBN;
          8:       n = ALU_SHL;
          default: n = 4'($urandom_range(15));
        endcase
        ins = {OPC_ALU, x, y, n};
      end
      OPC_KEY: begin
        case ($urandom_range(2))
          0:       ins = {OPC_KEY, x, KEY_DOWN};
          1:       ins = {OPC_KEY, x, KEY_UP};
          default: ins = {OPC_KEY, x, 8'($urandom_range(255))};
        endcase
      end
      OPC_MISC: begin
        case ($urandom_range(9))
          0:       kk = MISC_GDT;
          1:       kk = MISC_WKEY;
          2:       kk = MISC_SDT;
          3:       kk = MISC_SST;
          4:       kk = MISC_ADDI;
          5:       kk = MISC_FONT;
          6:       kk = MISC_BCD;
          7:       kk = MISC_SAVE;
          8:       kk = MISC_LOAD;
          default: kk = 8'($urandom_range(255));
        endcase
        ins = {OPC_MISC, x, kk};
      end
      default: ;
    endcase
    if (ins == INS_RET && !ret_allowed()) begin
      ins = INS_CLS;
    end
    return ins;
  endfunction

  // Offers one word after a random idle gap and waits until it is taken.
  task automatic send_word(input logic op, input logic [15:0] ins,
                           input logic [3:0] wb_idx, input logic [7:0] wb_val);
    logic [15:0] keys;
    logic [7:0]  delay_val;
    logic [7:0]  rnd;
    case ($urandom_range(7))
      0:       keys = 16'h0000;
      1:       keys = 16'hFFFF;
      default: keys = 16'($urandom_range(16'hFFFF));
    endcase
    delay_val = 8'($urandom_range(255));
    rnd       = 8'($urandom_range(255));
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'h0, wb_val, wb_idx, rnd, delay_val, keys, ins};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op == OP_EXEC) begin
      if (ins[15:12] == OPC_CALL) begin
        call_written[call_sp] = 1'b1;
        call_sp               = call_sp - 4'd1;
      end else if (ins == INS_RET) begin
        call_sp = call_sp + 4'd1;
      end
    end
  endtask

  task automatic send_exec(input logic [15:0] ins);
    send_word(OP_EXEC, ins, 4'($urandom_range(15)), 8'($urandom_range(255)));
  endtask

  task automatic send_writeback(input logic [3:0] idx, input logic [7:0] val);
    send_word(OP_WRITE, 16'($urandom_range(16'hFFFF)), idx, val);
  endtask

  // Waits until every predicted result word has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_start_address(input logic [15:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [15:0] phase_start [4];
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_start_address(16'hFFFF);

    // Directed: ALU flags, flag register as destination, stack, skips,
    // index and font, key numbers above 15, action requests, unknown words.
    send_writeback(4'h0, 8'hFF);
    send_writeback(4'h1, 8'h02);
    send_exec(16'h8014);
    send_exec(16'h8015);
    send_exec(16'h8016);
    send_exec(16'h801E);
    send_exec(16'h8017);
    send_exec(16'h8F14);
    send_exec(INS_CLS);
    send_exec(16'h2ABC);
    send_exec(INS_RET);
    send_exec(16'h5011);
    send_exec(16'hAFFF);
    send_exec(16'hF01E);
    send_exec(16'hF029);
    send_writeback(4'h2, 8'h10);
    send_exec(16'hE29E);
    send_exec(16'hE2A1);
    send_exec(16'hF00A);
    send_exec(16'hD12F);
    send_exec(16'hF055);
    send_exec(16'hF065);
    send_exec(16'hC3A5);
    send_exec(16'h0123);
    send_exec(16'h8AB8);
    send_exec(16'hFFFF);
    send_exec(16'hBFFF);

    // Random phases with different idle and stall mixes.
    phase_start[0] = 16'h0000;
    phase_start[1] = 16'($urandom_range(16'hFFFF));
    phase_start[2] = 16'hFFFF;
    phase_start[3] = START_ADDR_RESET;
    for (int p = 0; p < 4; p++) begin
      write_start_address(phase_start[p]);
      case (p)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 63;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 63;
        end
        default: begin
          send_idle_pct  = 9;
          recv_stall_pct = 9;
        end
      endcase
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if ($urandom_range(4) == 0) begin
          send_writeback(4'($urandom_range(15)), pick_value());
        end else begin
          send_exec(pick_instruction());
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
